FILE: sv/monotone_convex_hull_trick_top_defines.svh
// Assertion macros shared by the hull block checkers.
`ifndef MONOTONE_CONVEX_HULL_TRICK_TOP_DEFINES_SVH
`define MONOTONE_CONVEX_HULL_TRICK_TOP_DEFINES_SVH

// Condition and consequence checked in the same cycle.
`define MCHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence checked in the cycle after the condition.
`define MCHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mcht_pkg.sv
// Package with the widths, codes and types of the hull block.
package mcht_pkg;

	// Default stack depth.
	localparam int HULL_DEPTH_DEF = 1024;

	// Field widths of the items.
	localparam int SLOPE_W  = 32;
	localparam int ICPT_W   = 48;
	localparam int X_W      = 32;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;

	// Datapath widths of the redundancy test.
	localparam int DIFF_C_W = ICPT_W + 1;
	localparam int DIFF_M_W = SLOPE_W + 1;
	localparam int MUL_W    = DIFF_M_W;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int LO_W     = 24;
	localparam int HI_W     = DIFF_C_W - LO_W;
	localparam int ACC_W    = 84;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_QUERY  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// One stored line.
	typedef struct packed {
		logic signed [SLOPE_W-1:0] slope;
		logic signed [ICPT_W-1:0]  icpt;
	} line_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_I_L1,
		ST_I_L2,
		ST_I_MUL,
		ST_I_CMP,
		ST_I_PUSH,
		ST_Q_P,
		ST_Q_N,
		ST_Q_V,
		ST_Q_M,
		ST_DONE
	} state_t;

endpackage

FILE: sv/mcht_req_if.sv
// Input channel of the hull block: one insert or query item.
interface mcht_req_if;
	import mcht_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic signed [SLOPE_W-1:0] new_slope;
	logic signed [ICPT_W-1:0]  new_intercept;
	logic signed [X_W-1:0]     query_x;

	modport source (output valid, cmd, new_slope, new_intercept, query_x, input ready);
	modport sink (input valid, cmd, new_slope, new_intercept, query_x, output ready);
endinterface

FILE: sv/mcht_rsp_if.sv
// Output channel of the hull block: one result item per input item.
interface mcht_rsp_if #(
	parameter int CNT_W = $clog2(mcht_pkg::HULL_DEPTH_DEF + 1)
);
	import mcht_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] max_value;
	logic [STATUS_W-1:0]       status;
	logic [CNT_W-1:0]          hull_size;

	modport source (output valid, max_value, status, hull_size, input ready);
	modport sink (input valid, max_value, status, hull_size, output ready);
endinterface

FILE: sv/monotone_convex_hull_trick_top.sv
// Line stack for maximum queries, held in one memory with one registered read port.
// Insert: pushes at once with at most one line stored, else reads the top two lines and pops
// by equal slope (one read each) or by cross product (one read and five multiply steps each).
// Query: reads the line at the pointer and the next one, then steps the pointer while the value grows.
// One item at a time: the next item is taken only after the result is registered and the state is idle.
// Reset clears the state machine, line count, pointer and result valid; the memory is not cleared.
module monotone_convex_hull_trick_top #(
	parameter int HULL_DEPTH = mcht_pkg::HULL_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mcht_req_if.sink   req,
	mcht_rsp_if.source rsp
);
	import mcht_pkg::*;

	localparam int IDX_W = $clog2(HULL_DEPTH);
	localparam int CNT_W = $clog2(HULL_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HULL_DEPTH);
	localparam logic [2:0] MSTEP_LAST = 3'd4;

	// Control state.
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] ptr_q;
	logic [2:0]       mstep_q;
	logic             out_valid_q;

	// Line memory.
	line_t            mem [HULL_DEPTH];
	line_t            rd_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;

	// Item and working registers.
	logic signed [SLOPE_W-1:0]  new_m_q;
	logic signed [ICPT_W-1:0]   new_c_q;
	logic signed [X_W-1:0]      x_q;
	line_t                      l1_q, l2_q;
	logic signed [DIFF_C_W-1:0] lhs_a_q, rhs_a_q;
	logic signed [DIFF_M_W-1:0] lhs_b_q, rhs_b_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_l_q, acc_r_q;
	logic signed [ICPT_W-1:0]   qc_q;
	logic signed [VALUE_W-1:0]  vp_q;
	logic signed [VALUE_W-1:0]  res_value_q;
	status_t                    res_status_q;
	logic signed [VALUE_W-1:0]  out_value_q;
	status_t                    out_status_q;
	logic [CNT_W-1:0]           out_size_q;

	// Combinational helpers.
	logic                      accept, out_free, is_empty, is_full, is_query;
	logic [CNT_W-1:0]          last_idx, ptr_ext;
	logic [IDX_W-1:0]          ptr_clamp;
	logic                      has_next1, has_next2;
	logic                      eq_slope, redund_eq, redund_cross, pop, pop_more;
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [VALUE_W-1:0] val_sum;
	logic                      val_gt;

	assign accept   = req.valid && req.ready;
	assign is_query = (req.cmd == CMD_QUERY);
	assign out_free = !out_valid_q || rsp.ready;
	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q == CNT_FULL);
	assign last_idx = cnt_q - 1'b1;
	assign ptr_ext  = CNT_W'(ptr_q);

	// Pointer clamped to the top line; the neighbor checks for the query walk.
	assign ptr_clamp = (ptr_ext > last_idx) ? last_idx[IDX_W-1:0] : ptr_q;
	assign has_next1 = ptr_ext < last_idx;
	assign has_next2 = (ptr_ext + 1'b1) < last_idx;

	// Redundancy decision for the top line.
	assign eq_slope     = (l1_q.slope == new_m_q);
	assign redund_eq    = (new_c_q >= l1_q.icpt);
	assign redund_cross = (acc_l_q >= acc_r_q);
	assign pop          = ((state_q == ST_I_L2) && eq_slope && redund_eq) ||
		((state_q == ST_I_CMP) && redund_cross);
	assign pop_more     = (cnt_q > CNT_W'(2));

	// Shared multiplier and the line value adder.
	assign mul_p    = mul_a * mul_b;
	assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign val_sum  = $signed(prod_q[VALUE_W-1:0]) +
		$signed({{(VALUE_W - ICPT_W){qc_q[ICPT_W-1]}}, qc_q});
	assign val_gt   = (val_sum > vp_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_query) begin
						state_d = is_empty ? ST_DONE : ST_Q_P;
					end else if (is_full) begin
						state_d = ST_DONE;
					end else begin
						state_d = (cnt_q > CNT_W'(1)) ? ST_I_L1 : ST_I_PUSH;
					end
				end
			end
			ST_I_L1: state_d = ST_I_L2;
			ST_I_L2: begin
				if (!eq_slope) begin
					state_d = ST_I_MUL;
				end else begin
					state_d = (pop && pop_more) ? ST_I_L2 : ST_I_PUSH;
				end
			end
			ST_I_MUL: state_d = (mstep_q == MSTEP_LAST) ? ST_I_CMP : ST_I_MUL;
			ST_I_CMP: state_d = (pop && pop_more) ? ST_I_L2 : ST_I_PUSH;
			ST_I_PUSH: state_d = ST_DONE;
			ST_Q_P: state_d = ST_Q_N;
			ST_Q_N: state_d = has_next1 ? ST_Q_V : ST_DONE;
			ST_Q_V: state_d = (val_gt && has_next2) ? ST_Q_M : ST_DONE;
			ST_Q_M: state_d = ST_Q_V;
			ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port and multiplier operand selection.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		mul_a   = $signed({rd_q.slope[SLOPE_W-1], rd_q.slope});
		mul_b   = $signed({x_q[X_W-1], x_q});
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_query && !is_empty) begin
					rd_en   = 1'b1;
					rd_addr = ptr_clamp;
				end else if (accept && !is_query && (cnt_q > CNT_W'(1))) begin
					rd_en   = 1'b1;
					rd_addr = last_idx[IDX_W-1:0];
				end
			end
			ST_I_L1: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(cnt_q - CNT_W'(2));
			end
			ST_I_L2, ST_I_CMP: begin
				if (pop && pop_more) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(cnt_q - CNT_W'(3));
				end
			end
			ST_I_MUL: begin
				unique case (mstep_q)
					3'd0: begin
						mul_a = $signed({{(MUL_W - LO_W){1'b0}}, lhs_a_q[LO_W-1:0]});
						mul_b = lhs_b_q;
					end
					3'd1: begin
						mul_a = $signed({{(MUL_W - HI_W){lhs_a_q[DIFF_C_W-1]}},
							lhs_a_q[DIFF_C_W-1:LO_W]});
						mul_b = lhs_b_q;
					end
					3'd2: begin
						mul_a = $signed({{(MUL_W - LO_W){1'b0}}, rhs_a_q[LO_W-1:0]});
						mul_b = rhs_b_q;
					end
					3'd3: begin
						mul_a = $signed({{(MUL_W - HI_W){rhs_a_q[DIFF_C_W-1]}},
							rhs_a_q[DIFF_C_W-1:LO_W]});
						mul_b = rhs_b_q;
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			ST_I_PUSH: wr_en = 1'b1;
			ST_Q_P: begin
				if (has_next1) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(ptr_q + 1'b1);
				end
			end
			ST_Q_V: begin
				if (val_gt && has_next2) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(ptr_q + IDX_W'(2));
				end
			end
			ST_Q_N, ST_Q_M, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Line memory with registered read. A push is always followed by the done and
	// idle states before the next read, so no forwarding path is needed.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= '{slope: new_m_q, icpt: new_c_q};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ptr_q       <= '0;
			mstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				cnt_q <= last_idx;
			end else if (state_q == ST_I_PUSH) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if ((state_q == ST_IDLE) && accept && is_query && !is_empty) begin
				ptr_q <= ptr_clamp;
			end else if ((state_q == ST_I_PUSH) && !is_empty) begin
				ptr_q <= ptr_clamp;
			end else if ((state_q == ST_Q_V) && val_gt) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (state_q == ST_I_L2) begin
				mstep_q <= '0;
			end else if (state_q == ST_I_MUL) begin
				mstep_q <= mstep_q + 1'b1;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (accept) begin
			new_m_q       <= req.new_slope;
			new_c_q       <= req.new_intercept;
			x_q           <= req.query_x;
			res_value_q   <= '0;
			if (is_query) begin
				res_status_q <= is_empty ? STATUS_EMPTY : STATUS_OK;
			end else begin
				res_status_q <= is_full ? STATUS_FULL : STATUS_OK;
			end
		end
		unique case (state_q)
			ST_I_L1: l1_q <= rd_q;
			ST_I_L2: begin
				l2_q    <= rd_q;
				lhs_a_q <= $signed({rd_q.icpt[ICPT_W-1], rd_q.icpt}) -
					$signed({l1_q.icpt[ICPT_W-1], l1_q.icpt});
				lhs_b_q <= $signed({new_m_q[SLOPE_W-1], new_m_q}) -
					$signed({rd_q.slope[SLOPE_W-1], rd_q.slope});
				rhs_a_q <= $signed({rd_q.icpt[ICPT_W-1], rd_q.icpt}) -
					$signed({new_c_q[ICPT_W-1], new_c_q});
				rhs_b_q <= $signed({l1_q.slope[SLOPE_W-1], l1_q.slope}) -
					$signed({rd_q.slope[SLOPE_W-1], rd_q.slope});
				if (pop) begin
					l1_q <= rd_q;
				end
			end
			ST_I_MUL: begin
				unique case (mstep_q)
					3'd1: acc_l_q <= prod_ext;
					3'd2: acc_l_q <= acc_l_q + {prod_ext[ACC_W-1-LO_W:0], {LO_W{1'b0}}};
					3'd3: acc_r_q <= prod_ext;
					3'd4: acc_r_q <= acc_r_q + {prod_ext[ACC_W-1-LO_W:0], {LO_W{1'b0}}};
					default: begin
					end
				endcase
			end
			ST_I_CMP: begin
				if (pop) begin
					l1_q <= l2_q;
				end
			end
			ST_Q_P, ST_Q_M: qc_q <= rd_q.icpt;
			ST_Q_N: begin
				vp_q        <= val_sum;
				res_value_q <= val_sum;
				qc_q        <= rd_q.icpt;
			end
			ST_Q_V: begin
				if (val_gt) begin
					vp_q        <= val_sum;
					res_value_q <= val_sum;
				end else begin
					res_value_q <= vp_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_value_q  <= res_value_q;
					out_status_q <= res_status_q;
					out_size_q   <= cnt_q;
				end
			end
			ST_IDLE, ST_I_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	// Channel outputs.
	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.max_value = out_value_q;
	assign rsp.status    = out_status_q;
	assign rsp.hull_size = out_size_q;

endmodule

FILE: sv/mcht_checker.sv
// Port-level checker for the hull block and its bind to the top level.
`include "monotone_convex_hull_trick_top_defines.svh"

module mcht_checker #(
	parameter int HULL_DEPTH = mcht_pkg::HULL_DEPTH_DEF,
	localparam int CNT_W = $clog2(HULL_DEPTH + 1)
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [mcht_pkg::VALUE_W-1:0] rsp_value,
	input logic [mcht_pkg::STATUS_W-1:0]      rsp_status,
	input logic [CNT_W-1:0]                   rsp_size
);
	import mcht_pkg::*;

	// A stalled result stays offered.
	`MCHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	// The reported stack size never exceeds the depth.
	`MCHT_ASSERT_NOW(a_size_bound, rsp_valid, rsp_size <= CNT_W'(HULL_DEPTH), "hull size beyond depth")

	// A query on an empty stack reports zero value and zero size.
	`MCHT_ASSERT_NOW(a_empty_zero, rsp_valid && rsp_status == STATUS_EMPTY, rsp_value == '0 && rsp_size == '0, "empty query result not zero")

	// A dropped insert only happens on a full stack.
	`MCHT_ASSERT_NOW(a_full_size, rsp_valid && rsp_status == STATUS_FULL, rsp_value == '0 && rsp_size == CNT_W'(HULL_DEPTH), "dropped insert on a stack that is not full")

endmodule

bind monotone_convex_hull_trick_top mcht_checker #(
	.HULL_DEPTH(HULL_DEPTH)
) u_mcht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.max_value),
	.rsp_status(rsp.status),
	.rsp_size  (rsp.hull_size)
);
